/* src/mrp_pkg.sv */
// Shared types and constants for the Miller-Rabin primality test block.
package mrp_pkg;

	localparam int NUMBER_BITS = 63;
	localparam int CNT_W       = $clog2(NUMBER_BITS);
	localparam int S_TDATA_W   = ((2 * NUMBER_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W   = 8;

	typedef logic [NUMBER_BITS-1:0] num_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_STRIP,
		ST_REDUCE,
		ST_POW,
		ST_PMUL,
		ST_PSQR,
		ST_CHECK,
		ST_SQR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		num_t a;
		num_t b;
		num_t m;
	} mul_req_t;

	typedef struct packed {
		logic done;
		num_t p;
	} mul_rsp_t;

endpackage

/* src/mrp_mulmod.sv */
// Shared modular multiplier: (a * b) mod m, one bit of b per cycle by shift-add.
module mrp_mulmod (
	input  logic             clk,
	input  logic             arst_n,
	input  mrp_pkg::mul_req_t req,
	output mrp_pkg::mul_rsp_t rsp
);
	import mrp_pkg::*;

	num_t                   acc_q;
	num_t                   a_q;
	num_t                   b_q;
	num_t                   m_q;
	cnt_t                   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [NUMBER_BITS+1:0] sum;
	logic [NUMBER_BITS+1:0] m1;
	logic [NUMBER_BITS+1:0] m2;
	num_t                   acc_next;

	// 2*acc + bit*a stays below 3m; remove m or 2m
	always_comb begin
		sum = {1'b0, acc_q, 1'b0} + (b_q[NUMBER_BITS-1] ? {2'b00, a_q} : '0);
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		if (sum >= m2) begin
			acc_next = num_t'(sum - m2);
		end else if (sum >= m1) begin
			acc_next = num_t'(sum - m1);
		end else begin
			acc_next = num_t'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt_t'(NUMBER_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= {b_q[NUMBER_BITS-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

/* src/miller_rabin_primality_test.sv */
// Miller-Rabin primality test: one round per input transfer, verdict on the last witness.
// Trivial candidates (n <= 4 or even) skip from classification to the finish state;
// odd candidates strip factors of two, reduce the witness, exponentiate and square.
// Throughput: one item at a time; the shared modular multiplier, one bit per cycle,
// sets the rate. s_axis_tready is high only while the sequencer is idle.
// Reset: arst_n clears the sequencer, the output valid and sets the pass flag to 1.
module miller_rabin_primality_test (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mrp_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // candidate, witness, zero pad
	input  logic                           s_axis_tlast,  // last_witness
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mrp_pkg::M_TDATA_W-1:0]  m_axis_tdata   // probably_prime, zero pad
);
	import mrp_pkg::*;

	state_t   state_q;
	state_t   state_d;
	num_t     n_q;
	num_t     nm1_q;
	num_t     d_q;
	num_t     base_q;
	num_t     x_q;
	cnt_t     r_q;
	cnt_t     rem_q;
	logic     last_q;
	logic     pass_q;
	logic     flag_q;
	logic     out_valid_q;
	logic     out_data_q;
	logic     out_load;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	mrp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_FINISH) && last_q && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = x_q;
		mul_req.b     = base_q;
		mul_req.m     = n_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				if (n_q < num_t'(5) || !n_q[0]) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (d_q[0]) begin
					// reduce the witness modulo n as 1 * w mod n
					mul_req.start = 1'b1;
					mul_req.a     = num_t'(1);
					state_d       = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mul_rsp.done) state_d = ST_POW;
			end
			ST_POW: begin
				if (d_q == '0) begin
					state_d = ST_CHECK;
				end else if (d_q[0]) begin
					mul_req.start = 1'b1;
					state_d       = ST_PMUL;
				end else begin
					mul_req.start = 1'b1;
					mul_req.a     = base_q;
					state_d       = ST_PSQR;
				end
			end
			ST_PMUL: begin
				if (mul_rsp.done) state_d = ST_POW;
			end
			ST_PSQR: begin
				if (mul_rsp.done) state_d = ST_POW;
			end
			ST_CHECK: begin
				if (x_q == num_t'(1) || x_q == nm1_q || r_q <= cnt_t'(1)) begin
					state_d = ST_FINISH;
				end else begin
					mul_req.start = 1'b1;
					mul_req.b     = x_q;
					state_d       = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					if (mul_rsp.p == num_t'(1) || mul_rsp.p == nm1_q ||
					    rem_q == cnt_t'(1)) begin
						state_d = ST_FINISH;
					end else begin
						mul_req.start = 1'b1;
						mul_req.a     = mul_rsp.p;
						mul_req.b     = mul_rsp.p;
					end
				end
			end
			ST_FINISH: begin
				if (!last_q || out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q    <= s_axis_tdata[NUMBER_BITS-1:0];
				base_q <= s_axis_tdata[2*NUMBER_BITS-1:NUMBER_BITS];
				last_q <= s_axis_tlast;
			end
			ST_CLASSIFY: begin
				pass_q <= (n_q == num_t'(2)) || (n_q == num_t'(3));
				nm1_q  <= n_q - 1'b1;
				d_q    <= n_q - 1'b1;
				r_q    <= '0;
				x_q    <= num_t'(1);
			end
			ST_STRIP: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					r_q <= r_q + 1'b1;
				end
			end
			ST_REDUCE: begin
				if (mul_rsp.done) base_q <= mul_rsp.p;
			end
			ST_PMUL: begin
				if (mul_rsp.done) begin
					x_q    <= mul_rsp.p;
					d_q[0] <= 1'b0;
				end
			end
			ST_PSQR: begin
				if (mul_rsp.done) begin
					base_q <= mul_rsp.p;
					d_q    <= d_q >> 1;
				end
			end
			ST_CHECK: begin
				pass_q <= (x_q == num_t'(1)) || (x_q == nm1_q);
				rem_q  <= r_q - 1'b1;
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					x_q    <= mul_rsp.p;
					rem_q  <= rem_q - 1'b1;
					pass_q <= (mul_rsp.p == nm1_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_FINISH) begin
				if (!last_q) begin
					flag_q <= flag_q & pass_q;
				end else if (out_load) begin
					flag_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= flag_q & pass_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_data_q};

endmodule

/* src/mrp_checker.sv */
// Port-level checks for the primality test block and their binding.
module mrp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mrp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import mrp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("verdict dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after a transfer");

	a_verdict_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("verdict appeared while idle");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:1] == '0)
		else $error("output pad bits not zero");

endmodule

bind miller_rabin_primality_test mrp_checker u_mrp_checker (.*);
